### design/ami_pkg.sv
// Shared types and constants for the affine matrix inverse block.
// No dependencies; imported by every module of the block.
package ami_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int ROWS           = 3;

   typedef logic [1:0] col_type;

   // column 3 carries the inverse translation
   localparam col_type LAST_COL = 2'd3;

   typedef struct packed {
      col_type col;
      logic    sing;
   } tag_type;

endpackage

### design/ami_div.sv
// Pipelined rounding divider for three rows sharing one denominator, with saturation.
// Depends on ami_pkg.
module ami_div import ami_pkg::*; #(
   parameter int W = DATA_WIDTH_DEF,
   parameter int F = FRAC_BITS_DEF,
   localparam int MW = 3*W + 2*F + 3,
   localparam int RW = 4*W + 2*F + 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  tag_type                    in_tag,
   input  logic [ROWS-1:0][MW-1:0]    in_an,
   input  logic [MW-1:0]              in_ad,
   input  logic [ROWS-1:0]            in_neg,
   output logic                       out_valid,
   output tag_type                    out_tag,
   output logic [ROWS-1:0][W-1:0]     out_q
);

   localparam int NS = W + 1;
   localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

   logic [NS:0]     st_v_ff;
   tag_type         st_tag_ff [NS+1];
   logic [RW-1:0]   st_rem_ff [NS+1][ROWS];
   logic [RW-1:0]   st_den_ff [NS+1];
   logic [W-1:0]    st_q_ff   [NS+1][ROWS];
   logic [ROWS-1:0] st_ovf_ff [NS+1];
   logic [ROWS-1:0] st_neg_ff [NS+1];

   logic                   out_v_ff;
   tag_type                out_tag_ff;
   logic [ROWS-1:0][W-1:0] out_q_ff;

   logic [RW-1:0]          sub_w  [NS][ROWS];
   logic                   ge_w   [NS][ROWS];
   logic [W-1:0]           qbit_w [NS];
   logic [ROWS-1:0][W-1:0] res_in;

   // trial subtract of den << (W-k); step 0 only detects quotient overflow
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         qbit_w[k] = W'(1) << (W - k);
         for (int r = 0; r < ROWS; r++) begin
            sub_w[k][r] = st_den_ff[k] << (W - k);
            ge_w[k][r]  = st_rem_ff[k][r] >= sub_w[k][r];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         if (st_neg_ff[NS][r]) begin
            if (st_ovf_ff[NS][r] || (st_q_ff[NS][r] > HALF)) begin
               res_in[r] = HALF;
            end else begin
               res_in[r] = W'(-st_q_ff[NS][r]);
            end
         end else begin
            if (st_ovf_ff[NS][r] || st_q_ff[NS][r][W-1]) begin
               res_in[r] = ~HALF;
            end else begin
               res_in[r] = st_q_ff[NS][r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff  <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         st_v_ff  <= {st_v_ff[NS-1:0], in_valid};
         out_v_ff <= st_v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // rounding: q = floor((2|n| + |d|) / (2|d|))
         st_tag_ff[0] <= in_tag;
         st_den_ff[0] <= RW'(in_ad) << 1;
         st_neg_ff[0] <= in_neg;
         st_ovf_ff[0] <= '0;
         for (int r = 0; r < ROWS; r++) begin
            st_rem_ff[0][r] <= (RW'(in_an[r]) << 1) + RW'(in_ad);
            st_q_ff[0][r]   <= '0;
         end
         for (int k = 0; k < NS; k++) begin
            st_tag_ff[k+1] <= st_tag_ff[k];
            st_den_ff[k+1] <= st_den_ff[k];
            st_neg_ff[k+1] <= st_neg_ff[k];
            for (int r = 0; r < ROWS; r++) begin
               st_rem_ff[k+1][r] <= ge_w[k][r] ? st_rem_ff[k][r] - sub_w[k][r]
                                               : st_rem_ff[k][r];
               st_q_ff[k+1][r]   <= st_q_ff[k][r] | (ge_w[k][r] ? qbit_w[k] : '0);
               st_ovf_ff[k+1][r] <= st_ovf_ff[k][r] | (ge_w[k][r] && (k == 0));
            end
         end
         out_tag_ff <= st_tag_ff[NS];
         out_q_ff   <= res_in;
      end
   end

   assign out_valid = out_v_ff;
   assign out_tag   = out_tag_ff;
   assign out_q     = out_q_ff;

endmodule

### design/affine_matrix_inverse.sv
// Affine 4x4 matrix inverse: one input transfer yields four column transfers
// (columns 0..3, last flagged on column 3). The input is held in the issue
// stage while one column task per cycle enters a single pipeline, unless a
// result-side stall holds it; a new matrix is accepted as the last column of
// the previous one issues. The path to the output runs through the issue stage,
// six stages for cofactors, split products, sums and magnitudes, then the
// divider's entry stage, DATA_WIDTH + 1 quotient steps (the first only detects
// overflow) and its output register. A stall on the result side freezes the
// whole pipeline. Results are rounded to nearest (ties away from zero) and
// saturated; a zero determinant gives zero entries with singular set. Depends on ami_pkg and ami_div.
module affine_matrix_inverse import ami_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_e00,
   input  logic signed [DATA_WIDTH-1:0] req_e10,
   input  logic signed [DATA_WIDTH-1:0] req_e20,
   input  logic signed [DATA_WIDTH-1:0] req_e01,
   input  logic signed [DATA_WIDTH-1:0] req_e11,
   input  logic signed [DATA_WIDTH-1:0] req_e21,
   input  logic signed [DATA_WIDTH-1:0] req_e02,
   input  logic signed [DATA_WIDTH-1:0] req_e12,
   input  logic signed [DATA_WIDTH-1:0] req_e22,
   input  logic signed [DATA_WIDTH-1:0] req_trans_x,
   input  logic signed [DATA_WIDTH-1:0] req_trans_y,
   input  logic signed [DATA_WIDTH-1:0] req_trans_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_column_index,
   output logic signed [DATA_WIDTH-1:0] rsp_out_row0,
   output logic signed [DATA_WIDTH-1:0] rsp_out_row1,
   output logic signed [DATA_WIDTH-1:0] rsp_out_row2,
   output logic                         rsp_singular,
   output logic                         rsp_last
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PP = 2*W;            // cofactor product
   localparam int AW = 2*W + 1;        // adjugate entry
   localparam int PW = 2*W + 1;        // split partial product
   localparam int DW = 3*W + 2;        // determinant and translation sums
   localparam int MW = 3*W + 2*F + 3;  // dividend magnitude

   logic adv;
   logic issue_last;
   logic accept;

   // issue stage: holds the matrix while four column tasks go out
   logic                busy_ff;
   col_type             col_ff;
   logic signed [W-1:0] m_ff [3][3];
   logic signed [W-1:0] t_ff [3];

   logic [6:1] v_ff;

   // stage 1: cofactor products
   logic signed [PP-1:0] pa_ff [3][3];
   logic signed [PP-1:0] pb_ff [3][3];
   logic signed [PP-1:0] pa_in [3][3];
   logic signed [PP-1:0] pb_in [3][3];
   logic signed [W-1:0]  m0_1_ff [3];
   logic signed [W-1:0]  t1_ff   [3];
   col_type              col1_ff;

   // stage 2: adjugate
   logic signed [AW-1:0] adj2_ff [3][3];
   logic signed [W-1:0]  m0_2_ff [3];
   logic signed [W-1:0]  t2_ff   [3];
   col_type              col2_ff;

   // stage 3: split partial products, adjugate column picked
   logic signed [PW-1:0] dh3_ff [3];
   logic signed [PW-1:0] dl3_ff [3];
   logic signed [PW-1:0] th3_ff [3][3];
   logic signed [PW-1:0] tl3_ff [3][3];
   logic signed [AW-1:0] acol3_ff [3];
   logic signed [PW-1:0] dh_in [3];
   logic signed [PW-1:0] dl_in [3];
   logic signed [PW-1:0] th_in [3][3];
   logic signed [PW-1:0] tl_in [3][3];
   logic signed [AW-1:0] acol_in [3];
   col_type              col3_ff;

   // stage 4: recombined terms
   logic signed [DW-1:0] dt4_ff [3];
   logic signed [DW-1:0] st4_ff [3][3];
   logic signed [AW-1:0] acol4_ff [3];
   col_type              col4_ff;

   // stage 5: determinant and adj * t
   logic signed [DW-1:0] det5_ff;
   logic signed [DW-1:0] s5_ff [3];
   logic signed [AW-1:0] acol5_ff [3];
   col_type              col5_ff;

   // stage 6: magnitudes and signs for the divider
   logic [ROWS-1:0][MW-1:0] an6_ff;
   logic [MW-1:0]           ad6_ff;
   logic [ROWS-1:0]         neg6_ff;
   tag_type                 tag6_ff;
   logic [ROWS-1:0][MW-1:0] an_in;
   logic [ROWS-1:0]         neg_in;
   logic [DW-1:0]           dabs;
   logic [DW-1:0]           sabs [3];
   logic [AW-1:0]           aabs [3];

   logic                   div_valid;
   tag_type                div_tag;
   logic [ROWS-1:0][W-1:0] div_q;

   // whole pipeline moves unless a shown result is stalled
   assign adv        = !rsp_valid || !rsp_stall;
   assign issue_last = busy_ff && (col_ff == LAST_COL) && adv;
   assign req_stall  = busy_ff && !issue_last;
   assign accept     = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         col_ff  <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         col_ff  <= '0;
      end else if (adv && busy_ff) begin
         busy_ff <= (col_ff != LAST_COL);
         col_ff  <= col_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         m_ff[0][0] <= req_e00;  m_ff[0][1] <= req_e01;  m_ff[0][2] <= req_e02;
         m_ff[1][0] <= req_e10;  m_ff[1][1] <= req_e11;  m_ff[1][2] <= req_e12;
         m_ff[2][0] <= req_e20;  m_ff[2][1] <= req_e21;  m_ff[2][2] <= req_e22;
         t_ff[0]    <= req_trans_x;
         t_ff[1]    <= req_trans_y;
         t_ff[2]    <= req_trans_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[5:1], busy_ff};
      end
   end

   // adj[r][c] = pa - pb
   always_comb begin
      pa_in[0][0] = m_ff[1][1] * m_ff[2][2];  pb_in[0][0] = m_ff[2][1] * m_ff[1][2];
      pa_in[0][1] = m_ff[2][1] * m_ff[0][2];  pb_in[0][1] = m_ff[0][1] * m_ff[2][2];
      pa_in[0][2] = m_ff[0][1] * m_ff[1][2];  pb_in[0][2] = m_ff[1][1] * m_ff[0][2];
      pa_in[1][0] = m_ff[2][0] * m_ff[1][2];  pb_in[1][0] = m_ff[1][0] * m_ff[2][2];
      pa_in[1][1] = m_ff[0][0] * m_ff[2][2];  pb_in[1][1] = m_ff[2][0] * m_ff[0][2];
      pa_in[1][2] = m_ff[1][0] * m_ff[0][2];  pb_in[1][2] = m_ff[0][0] * m_ff[1][2];
      pa_in[2][0] = m_ff[1][0] * m_ff[2][1];  pb_in[2][0] = m_ff[2][0] * m_ff[1][1];
      pa_in[2][1] = m_ff[2][0] * m_ff[0][1];  pb_in[2][1] = m_ff[0][0] * m_ff[2][1];
      pa_in[2][2] = m_ff[0][0] * m_ff[1][1];  pb_in[2][2] = m_ff[1][0] * m_ff[0][1];
   end

   // adjugate entries are split into a signed high and unsigned low half
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dh_in[j] = m0_2_ff[j] * $signed(adj2_ff[j][0][AW-1:W]);
         dl_in[j] = m0_2_ff[j] * $signed({1'b0, adj2_ff[j][0][W-1:0]});
         acol_in[j] = (col2_ff == LAST_COL) ? '0 : adj2_ff[j][col2_ff];
         for (int k = 0; k < 3; k++) begin
            th_in[j][k] = t2_ff[k] * $signed(adj2_ff[j][k][AW-1:W]);
            tl_in[j][k] = t2_ff[k] * $signed({1'b0, adj2_ff[j][k][W-1:0]});
         end
      end
   end

   // linear columns divide adj << 2F; translation divides -(adj t) << F
   always_comb begin
      dabs = det5_ff[DW-1] ? DW'(-det5_ff) : DW'(det5_ff);
      for (int r = 0; r < ROWS; r++) begin
         sabs[r] = s5_ff[r][DW-1] ? DW'(-s5_ff[r]) : DW'(s5_ff[r]);
         aabs[r] = acol5_ff[r][AW-1] ? AW'(-acol5_ff[r]) : AW'(acol5_ff[r]);
         if (col5_ff == LAST_COL) begin
            an_in[r]  = MW'(sabs[r]) << F;
            neg_in[r] = (!s5_ff[r][DW-1] && (s5_ff[r] != '0)) ^ det5_ff[DW-1];
         end else begin
            an_in[r]  = MW'(aabs[r]) << (2*F);
            neg_in[r] = acol5_ff[r][AW-1] ^ det5_ff[DW-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         m0_1_ff <= m_ff[0];
         t1_ff   <= t_ff;
         col1_ff <= col_ff;
         // stage 2
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               adj2_ff[r][c] <= AW'(pa_ff[r][c]) - AW'(pb_ff[r][c]);
            end
         end
         m0_2_ff <= m0_1_ff;
         t2_ff   <= t1_ff;
         col2_ff <= col1_ff;
         // stage 3
         dh3_ff   <= dh_in;
         dl3_ff   <= dl_in;
         th3_ff   <= th_in;
         tl3_ff   <= tl_in;
         acol3_ff <= acol_in;
         col3_ff  <= col2_ff;
         // stage 4
         for (int j = 0; j < 3; j++) begin
            dt4_ff[j] <= (DW'(dh3_ff[j]) <<< W) + DW'(dl3_ff[j]);
            for (int k = 0; k < 3; k++) begin
               st4_ff[j][k] <= (DW'(th3_ff[j][k]) <<< W) + DW'(tl3_ff[j][k]);
            end
         end
         acol4_ff <= acol3_ff;
         col4_ff  <= col3_ff;
         // stage 5
         det5_ff <= dt4_ff[0] + dt4_ff[1] + dt4_ff[2];
         for (int r = 0; r < 3; r++) begin
            s5_ff[r] <= st4_ff[r][0] + st4_ff[r][1] + st4_ff[r][2];
         end
         acol5_ff <= acol4_ff;
         col5_ff  <= col4_ff;
         // stage 6
         an6_ff  <= an_in;
         ad6_ff  <= MW'(dabs);
         neg6_ff <= neg_in;
         tag6_ff <= '{col: col5_ff, sing: (det5_ff == '0)};
      end
   end

   ami_div #(
      .W (W),
      .F (F)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v_ff[6]),
      .in_tag    (tag6_ff),
      .in_an     (an6_ff),
      .in_ad     (ad6_ff),
      .in_neg    (neg6_ff),
      .out_valid (div_valid),
      .out_tag   (div_tag),
      .out_q     (div_q)
   );

   // singular matrices show zero entries
   assign rsp_valid        = div_valid;
   assign rsp_column_index = div_tag.col;
   assign rsp_singular     = div_tag.sing;
   assign rsp_last         = (div_tag.col == LAST_COL);
   assign rsp_out_row0     = div_tag.sing ? '0 : div_q[0];
   assign rsp_out_row1     = div_tag.sing ? '0 : div_q[1];
   assign rsp_out_row2     = div_tag.sing ? '0 : div_q[2];

endmodule

### design/ami_chk.sv
// Port-level checks for the affine matrix inverse block, bound to its top level.
// Depends on ami_pkg and affine_matrix_inverse.
module ami_chk import ami_pkg::*; #(
   parameter int W = DATA_WIDTH_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_column_index,
   input logic signed [W-1:0] rsp_out_row0,
   input logic signed [W-1:0] rsp_out_row1,
   input logic signed [W-1:0] rsp_out_row2,
   input logic                rsp_singular,
   input logic                rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_column_index)
         && $stable(rsp_out_row0) && $stable(rsp_out_row1) && $stable(rsp_out_row2))
      else $error("stalled result changed");

   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_column_index == LAST_COL)))
      else $error("last flag off column 3");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> (rsp_out_row0 == '0) && (rsp_out_row1 == '0)
         && (rsp_out_row2 == '0))
      else $error("singular result not zero");

   // four column transfers per matrix: no new matrix right after one is taken
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while columns still issuing");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind affine_matrix_inverse ami_chk #(.W(DATA_WIDTH)) u_ami_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_column_index (rsp_column_index),
   .rsp_out_row0     (rsp_out_row0),
   .rsp_out_row1     (rsp_out_row1),
   .rsp_out_row2     (rsp_out_row2),
   .rsp_singular     (rsp_singular),
   .rsp_last         (rsp_last)
);

### sim/affine_matrix_inverse_checker.sv
// Checker for the affine matrix inverse: watches both channels, predicts the
// four column transfers of each accepted matrix and compares them in order.
// Depends on ami_pkg.
`timescale 1ns / 100ps

module affine_matrix_inverse_checker import ami_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_e00,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_e10,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_e20,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_e01,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_e11,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_e21,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_e02,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_e12,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_e22,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_trans_x,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_trans_y,
   input  logic signed [DATA_WIDTH_DEF-1:0] req_trans_z,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [1:0]                       rsp_column_index,
   input  logic signed [DATA_WIDTH_DEF-1:0] rsp_out_row0,
   input  logic signed [DATA_WIDTH_DEF-1:0] rsp_out_row1,
   input  logic signed [DATA_WIDTH_DEF-1:0] rsp_out_row2,
   input  logic                             rsp_singular,
   input  logic                             rsp_last,
   output int                               mismatches,
   output int                               columns_owed
);

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;

   typedef logic signed [DW-1:0]  word_type;
   typedef logic signed [191:0]   big_type;

   typedef struct {
      col_type  col;
      word_type row [ROWS];
      logic     sing;
      logic     last;
   } column_type;

   column_type inverse_cols [$];

   task automatic report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // n / d rounded to nearest, ties away from zero
   function automatic big_type round_div(input big_type n, input big_type d);
      big_type an, ad, q;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q  = (2 * an + ad) / (2 * ad);
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic word_type clamp(input big_type v);
      big_type hi, lo;
      hi = (big_type'(1) <<< (DW - 1)) - 1;
      lo = -(big_type'(1) <<< (DW - 1));
      if (v > hi) return word_type'(hi);
      if (v < lo) return word_type'(lo);
      return word_type'(v);
   endfunction

   // Adjugate and determinant in full width, each output rounded once.
   task automatic predict_inverse();
      big_type    m [3][3];
      big_type    t [3];
      big_type    adj [3][3];
      big_type    det, s;
      word_type   res [3][4];
      column_type c;
      m[0][0] = req_e00; m[1][0] = req_e10; m[2][0] = req_e20;
      m[0][1] = req_e01; m[1][1] = req_e11; m[2][1] = req_e21;
      m[0][2] = req_e02; m[1][2] = req_e12; m[2][2] = req_e22;
      t[0] = req_trans_x; t[1] = req_trans_y; t[2] = req_trans_z;
      adj[0][0] = m[1][1] * m[2][2] - m[2][1] * m[1][2];
      adj[0][1] = m[2][1] * m[0][2] - m[0][1] * m[2][2];
      adj[0][2] = m[0][1] * m[1][2] - m[1][1] * m[0][2];
      adj[1][0] = m[2][0] * m[1][2] - m[1][0] * m[2][2];
      adj[1][1] = m[0][0] * m[2][2] - m[2][0] * m[0][2];
      adj[1][2] = m[1][0] * m[0][2] - m[0][0] * m[1][2];
      adj[2][0] = m[1][0] * m[2][1] - m[2][0] * m[1][1];
      adj[2][1] = m[2][0] * m[0][1] - m[0][0] * m[2][1];
      adj[2][2] = m[0][0] * m[1][1] - m[1][0] * m[0][1];
      det = m[0][0] * adj[0][0] + m[0][1] * adj[1][0] + m[0][2] * adj[2][0];
      for (int r = 0; r < 3; r++) begin
         if (det == 0) begin
            for (int k = 0; k < 4; k++) res[r][k] = '0;
         end else begin
            for (int k = 0; k < 3; k++)
               res[r][k] = clamp(round_div(adj[r][k] <<< (2 * FB), det));
            s = adj[r][0] * t[0] + adj[r][1] * t[1] + adj[r][2] * t[2];
            res[r][3] = clamp(round_div((-s) <<< FB, det));
         end
      end
      for (int k = 0; k < 4; k++) begin
         c.col  = col_type'(k);
         for (int r = 0; r < 3; r++) c.row[r] = res[r][k];
         c.sing = (det == 0);
         c.last = (col_type'(k) == LAST_COL);
         inverse_cols.push_back(c);
      end
   endtask

   always @(posedge clock) begin
      column_type want;
      if (reset) begin
         inverse_cols.delete();
         mismatches   = 0;
         columns_owed = 0;
      end else begin
         if (req_valid && !req_stall) predict_inverse();
         if (rsp_valid && !rsp_stall) begin
            if (inverse_cols.size() == 0) begin
               report($sformatf("column %0d with nothing expected", rsp_column_index));
            end else begin
               want = inverse_cols.pop_front();
               if (rsp_column_index !== want.col)
                  report($sformatf("column_index %0d want %0d", rsp_column_index, want.col));
               if (rsp_out_row0 !== want.row[0])
                  report($sformatf("col %0d row0 %h want %h", want.col, rsp_out_row0,
                                   want.row[0]));
               if (rsp_out_row1 !== want.row[1])
                  report($sformatf("col %0d row1 %h want %h", want.col, rsp_out_row1,
                                   want.row[1]));
               if (rsp_out_row2 !== want.row[2])
                  report($sformatf("col %0d row2 %h want %h", want.col, rsp_out_row2,
                                   want.row[2]));
               if (rsp_singular !== want.sing)
                  report($sformatf("col %0d singular %b want %b", want.col, rsp_singular,
                                   want.sing));
               if (rsp_last !== want.last)
                  report($sformatf("col %0d last %b want %b", want.col, rsp_last,
                                   want.last));
            end
         end
         columns_owed = inverse_cols.size();
      end
   end

endmodule

### sim/testbench.sv
// Top of the affine matrix inverse testbench: clock, reset, matrix stimulus
// and result-side stalls; verdict from affine_matrix_inverse_checker.
// Depends on ami_pkg, the block and the checker.
`timescale 1ns / 100ps

module testbench import ami_pkg::*;;

   localparam int DW        = DATA_WIDTH_DEF;
   localparam int FB        = FRAC_BITS_DEF;
   localparam int RAND_MATS = 410;
   localparam int CYCLE_CAP = 300000;
   localparam int DRAIN     = DW + 40;

   typedef logic signed [DW-1:0] word_type;
   typedef word_type mat_type [12];   // e00 e10 e20 e01 e11 e21 e02 e12 e22 tx ty tz

   localparam word_type ONE  = word_type'(1) <<< FB;
   localparam word_type WMAX = {1'b0, {(DW-1){1'b1}}};
   localparam word_type WMIN = {1'b1, {(DW-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   word_type req_e00 = '0, req_e10 = '0, req_e20 = '0;
   word_type req_e01 = '0, req_e11 = '0, req_e21 = '0;
   word_type req_e02 = '0, req_e12 = '0, req_e22 = '0;
   word_type req_trans_x = '0, req_trans_y = '0, req_trans_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_column_index;
   word_type rsp_out_row0, rsp_out_row1, rsp_out_row2;
   logic rsp_singular, rsp_last;

   int mismatches;
   int columns_owed;
   int cycle = 0;
   bit calm = 1'b0;        // no idling on either side while set, outside the long hold-off

   always #5 clock = ~clock;

   affine_matrix_inverse dut (.*);

   affine_matrix_inverse_checker checker_i (.*);

   // Result side: random stalls, plus one long hold-off so the pipeline
   // backs up and the block stalls its input while items keep coming.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle == 10) reset <= 1'b0;
      if (cycle >= 300 && cycle < 700)
         rsp_stall <= 1'b1;
      else if (calm)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < 9);
   end

   // generous cap; a hang ends here
   always @(posedge clock) begin
      if (cycle == CYCLE_CAP) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // One matrix transfer: payload and valid set at an edge, then held until
   // the block is seen not stalling (sampled mid-cycle), then the edge.
   task automatic send_matrix(input mat_type v);
      req_valid   <= 1'b1;
      req_e00     <= v[0];  req_e10 <= v[1];  req_e20 <= v[2];
      req_e01     <= v[3];  req_e11 <= v[4];  req_e21 <= v[5];
      req_e02     <= v[6];  req_e12 <= v[7];  req_e22 <= v[8];
      req_trans_x <= v[9];  req_trans_y <= v[10]; req_trans_z <= v[11];
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic word_type any_word();
      return word_type'($urandom);
   endfunction

   // Mostly moderate entries (about +-8.0) so inverses stay in range.
   function automatic word_type mid_word();
      return word_type'($signed($urandom_range(0, 2 ** (FB + 4) - 1)) - 2 ** (FB + 3));
   endfunction

   function automatic mat_type random_matrix();
      mat_type v;
      int      pick, a, b;
      pick = $urandom_range(99);
      for (int i = 0; i < 12; i++) begin
         if (pick < 15)      v[i] = any_word();
         else if (pick < 25) v[i] = word_type'($signed($urandom_range(0, 511)) - 256);
         else                v[i] = mid_word();
      end
      if (pick >= 90) begin
         // rank-deficient: one column a copy or negation of another
         a = $urandom_range(2);
         b = (a + 1 + $urandom_range(1)) % 3;
         for (int r = 0; r < 3; r++) v[3*b + r] = ($urandom_range(1)) ? v[3*a + r]
                                                                      : -v[3*a + r];
      end else if (pick >= 85) begin
         for (int i = 0; i < 12; i++)
            if ($urandom_range(3) == 0) v[i] = $urandom_range(1) ? WMAX : WMIN;
      end
      return v;
   endfunction

   function automatic mat_type diag(input word_type d0, d1, d2, tx, ty, tz);
      mat_type v;
      for (int i = 0; i < 9; i++) v[i] = '0;
      v[0] = d0; v[4] = d1; v[8] = d2;
      v[9] = tx; v[10] = ty; v[11] = tz;
      return v;
   endfunction

   initial begin
      mat_type v;
      mat_type directed [$];
      while (reset) @(posedge clock);

      // identity, scalings, rounding, saturation, singular cases
      directed.push_back(diag(ONE, ONE, ONE, '0, '0, '0));
      directed.push_back(diag(ONE, ONE, ONE, WMAX, WMIN, ONE));
      directed.push_back(diag(2 * ONE, 4 * ONE, -ONE, 3 * ONE, ONE, -ONE));
      directed.push_back(diag(3 * ONE, 3 * ONE, 3 * ONE, ONE, ONE, ONE));
      directed.push_back(diag(word_type'(1), word_type'(1), word_type'(1), ONE, -ONE, '0));
      directed.push_back(diag(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX));
      directed.push_back(diag(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN));
      directed.push_back(diag(-ONE, ONE, WMIN, '0, WMAX, WMIN));
      directed.push_back(diag('0, '0, '0, '0, '0, '0));
      directed.push_back(diag(ONE, '0, ONE, ONE, ONE, ONE));
      for (int i = 0; i < 12; i++) v[i] = WMAX;
      directed.push_back(v);
      for (int i = 0; i < 12; i++) v[i] = WMIN;
      directed.push_back(v);
      for (int i = 0; i < 12; i++) v[i] = (i % 2) ? WMIN : WMAX;
      directed.push_back(v);
      for (int i = 0; i < 12; i++) v[i] = '1;
      directed.push_back(v);
      // rotation-like with shear
      v = diag(ONE, ONE, ONE, 5 * ONE, -7 * ONE, ONE / 2);
      v[3] = ONE / 2; v[1] = -ONE / 3; v[7] = ONE / 5;
      directed.push_back(v);
      foreach (directed[i]) send_matrix(directed[i]);

      for (int n = 0; n < RAND_MATS; n++) begin
         calm = (n >= 150 && n < 250);
         if (n == 260) begin
            // sender pause until every column transfer has come back
            req_valid <= 1'b0;
            @(posedge clock);
            while (columns_owed != 0) @(posedge clock);
         end
         send_matrix(random_matrix());
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      @(posedge clock);
      while (columns_owed != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0 && columns_owed == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
design/ami_pkg.sv
design/ami_div.sv
design/affine_matrix_inverse.sv
design/ami_chk.sv
sim/affine_matrix_inverse_checker.sv
sim/testbench.sv
